/* design/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared opcodes, status codes, register indexes and sizes of the heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXT_MAX = 2'd1;
    localparam logic [1:0] OP_EXT_MIN = 2'd2;
    localparam logic [1:0] OP_EXT_IDX = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_SIGNED   = 1'b1;

    // heap size and key width, fixed by the stream field layout
    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
endpackage

/* design/bmhq_ram.sv */
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/binary_max_heap_queue_core.sv */
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core
// Binary max-heap priority queue held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (tdata: opcode, key_in, position from bit 0 up).
//   Each request gives one result on m_axis (tdata: key_out, status,
//   count_after from bit 0 up). Registers are written through i_cfg_* while
//   the block is idle: index 0 capacity, index 1 signed compare.
//   One request is worked at a time through a single-port key RAM; the moving
//   key is held in a register and written once, into its final slot. Per request:
//     insert          the new key climbs from the next free slot
//     extract max     the root is taken, the last key descends from it
//     extract min     the leaves are scanned, then as extract at index
//     extract index   the slot is taken, the last key climbs or descends
//   The result is held in an output register; while the receiver stalls the
//   result waits and no new request is taken.
//   Reset (synchronous, active low) empties the heap and restores capacity 64
//   and unsigned compare. RAM contents need no clearing: only entries below
//   the count are ever read.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core
    import bmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode[1:0], key_in[33:2], position[39:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // key_out[31:0], status[33:32], count[40:34]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;  // read parent of hole
    localparam logic [3:0] S_UP_CMP   = 4'd2;  // parent arrives, move or stop
    localparam logic [3:0] S_DN_RL    = 4'd3;  // read left child
    localparam logic [3:0] S_DN_RR    = 4'd4;  // capture left, read right
    localparam logic [3:0] S_DN_CMP   = 4'd5;  // pick larger, move or stop
    localparam logic [3:0] S_SC_FIRST = 4'd6;  // first leaf arrives
    localparam logic [3:0] S_SC_CMP   = 4'd7;  // next leaf arrives
    localparam logic [3:0] S_RM_ADR   = 4'd8;  // read removed slot
    localparam logic [3:0] S_RM_KEY   = 4'd9;  // removed key arrives, read last
    localparam logic [3:0] S_RM_LAST  = 4'd10; // last key arrives
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0]           r_st;
    logic [CW-1:0]        r_cnt;
    logic [6:0]           r_cap;
    logic                 r_sgn;
    logic [AW-1:0]        r_i, r_j, r_m;
    logic [KEY_WIDTH-1:0] r_ki, r_kl, r_km;
    logic                 r_hr;        // right child present
    logic                 r_moved;     // key climbed at least once
    logic [1:0]           r_op;
    logic [CW-1:0]        r_scan;
    logic [KEY_WIDTH-1:0] r_kout;
    logic [1:0]           r_status;
    logic                 r_ovalid;

    logic                 we;
    logic [AW-1:0]        addr;
    logic [KEY_WIDTH-1:0] wdata, rdata;

    bmhq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    function automatic logic gt(input logic [KEY_WIDTH-1:0] a,
                                input logic [KEY_WIDTH-1:0] b, input logic s);
        logic [KEY_WIDTH-1:0] x, y;
        x = a; y = b;
        x[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ s;
        y[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ s;
        return x > y;
    endfunction

    logic [1:0]           in_op;
    logic [KEY_WIDTH-1:0] in_key;
    logic [5:0]           in_pos;
    logic                 accept;
    logic [CW-1:0]        cap_eff;
    logic [AW+1:0]        lft, rgt, cnt_x;
    logic [AW-1:0]        par, last_ix;
    logic                 up_done, up_swap;
    logic                 dn_take_l, dn_take_r, dn_stay;
    logic [KEY_WIDTH-1:0] dn_kbl, dn_kb;
    logic [AW-1:0]        dn_big;
    logic                 sc_less;

    assign in_op   = s_axis_tdata[1:0];
    assign in_key  = s_axis_tdata[KEY_WIDTH+1:2];
    assign in_pos  = s_axis_tdata[39:34];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign cap_eff = (r_cap > 7'(DEPTH)) ? CW'(DEPTH) : CW'(r_cap);
    assign cnt_x   = (AW+2)'(r_cnt);
    assign lft     = {1'b0, r_i, 1'b1};
    assign rgt     = lft + (AW+2)'(1);
    assign par     = AW'((r_i - AW'(1)) >> 1);
    assign last_ix = AW'(r_cnt - CW'(1));

    // sift decisions
    assign up_done   = (r_op == OP_INSERT) || r_moved;
    assign up_swap   = gt(r_ki, rdata, r_sgn);
    assign dn_take_l = gt(r_kl, r_ki, r_sgn);
    assign dn_kbl    = dn_take_l ? r_kl : r_ki;
    assign dn_take_r = r_hr && gt(rdata, dn_kbl, r_sgn);
    assign dn_kb     = dn_take_r ? rdata : dn_kbl;
    assign dn_big    = dn_take_r ? AW'(rgt) : (dn_take_l ? AW'(lft) : r_i);
    assign dn_stay   = !dn_take_l && !dn_take_r;
    assign sc_less   = gt(r_km, rdata, r_sgn);

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_cnt, r_status, r_kout};

    // RAM port control
    always_comb begin
        we = 1'b0; addr = r_i; wdata = r_ki;
        unique case (r_st)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_EXT_MIN)      addr = AW'(r_cnt >> 1);
                    else if (in_op == OP_EXT_MAX) addr = '0;
                    else                          addr = AW'(in_pos);
                end
            end
            S_UP_RD: begin
                if (r_i == '0) we = up_done;
                else addr = par;
            end
            S_UP_CMP: begin
                we = up_swap || up_done;
                wdata = up_swap ? rdata : r_ki;
            end
            S_DN_RL: begin
                if (lft >= cnt_x) we = 1'b1;
                else addr = AW'(lft);
            end
            S_DN_RR:              addr = AW'(rgt);
            S_DN_CMP: begin
                we = 1'b1; wdata = dn_kb;
            end
            S_SC_FIRST, S_SC_CMP: addr = AW'(r_scan);
            S_RM_ADR:             addr = r_i;
            S_RM_KEY:             addr = last_ix;
            default:              addr = r_i;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_cap <= 7'd64; r_sgn <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CAPACITY) r_cap <= i_cfg_wdata;
                else if (i_cfg_index == REG_SIGNED) r_sgn <= i_cfg_wdata[0];
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (accept) begin
                    r_op <= in_op; r_kout <= '0; r_status <= ST_DONE; r_moved <= 1'b0;
                    if (in_op == OP_INSERT) begin
                        if (r_cnt >= cap_eff) begin
                            r_status <= ST_FULL; r_st <= S_OUT;
                        end else begin
                            r_i <= AW'(r_cnt); r_ki <= in_key;
                            r_cnt <= r_cnt + CW'(1); r_st <= S_UP_RD;
                        end
                    end else if (r_cnt == '0 ||
                                 (in_op == OP_EXT_IDX && CW'(in_pos) >= r_cnt)) begin
                        r_status <= ST_EMPTY; r_st <= S_OUT;
                    end else if (in_op == OP_EXT_MIN) begin
                        r_m <= AW'(r_cnt >> 1);
                        r_scan <= (r_cnt >> 1) + CW'(1);
                        r_st <= S_SC_FIRST;
                    end else begin
                        r_i <= (in_op == OP_EXT_MAX) ? AW'(0) : AW'(in_pos);
                        r_st <= S_RM_KEY;
                    end
                end
                // leaf scan, lowest index kept on ties
                S_SC_FIRST: begin
                    r_km <= rdata;
                    if (r_scan < r_cnt) begin
                        r_j <= AW'(r_scan); r_scan <= r_scan + CW'(1); r_st <= S_SC_CMP;
                    end else begin
                        r_i <= r_m; r_st <= S_RM_ADR;
                    end
                end
                S_SC_CMP: begin
                    if (sc_less) begin r_km <= rdata; r_m <= r_j; end
                    if (r_scan < r_cnt) begin
                        r_j <= AW'(r_scan); r_scan <= r_scan + CW'(1);
                    end else begin
                        r_i <= sc_less ? r_j : r_m; r_st <= S_RM_ADR;
                    end
                end
                S_RM_ADR: r_st <= S_RM_KEY;
                // removed key arrives; fetch last unless it is the removed slot
                S_RM_KEY: begin
                    r_kout <= rdata;
                    r_cnt <= r_cnt - CW'(1);
                    r_st <= (last_ix == r_i) ? S_OUT : S_RM_LAST;
                end
                S_RM_LAST: begin
                    r_ki <= rdata;
                    r_st <= (r_op == OP_EXT_MAX) ? S_DN_RL : S_UP_RD;
                end
                // sift up
                S_UP_RD: begin
                    if (r_i == '0) r_st <= up_done ? S_OUT : S_DN_RL;
                    else r_st <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (up_swap) begin
                        r_i <= par; r_moved <= 1'b1; r_st <= S_UP_RD;
                    end else begin
                        r_st <= up_done ? S_OUT : S_DN_RL;
                    end
                end
                // sift down
                S_DN_RL: r_st <= (lft >= cnt_x) ? S_OUT : S_DN_RR;
                S_DN_RR: begin
                    r_kl <= rdata; r_hr <= (rgt < cnt_x); r_st <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (dn_stay) r_st <= S_OUT;
                    else begin r_i <= dn_big; r_st <= S_DN_RL; end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("count above depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("accept while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] != ST_DONE) |-> m_axis_tdata[31:0] == '0)
        else $error("failed op returns key");
endmodule

/* bench/binary_max_heap_queue_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core_tb
// Drives heap requests on the slave stream, predicts every result with a
// behavioral max-heap and checks each result on the master stream in order.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core_tb
    import bmhq_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode[1:0], key_in[33:2], position[39:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // key_out[31:0], status[33:32], count[40:34]
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_wdata;

    typedef struct packed {
        logic [6:0]  count_after;
        logic [1:0]  status;
        logic [31:0] key_out;
    } t_heap_result;

    // behavioral heap state
    logic [31:0] mdl_heap [64];
    int          mdl_count;
    int          mdl_capacity;
    bit          mdl_signed;

    t_heap_result pending_results[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;

    binary_max_heap_queue_core i_dut (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // --- prediction ---
    function automatic bit key_gt(logic [31:0] a, logic [31:0] b);
        if (mdl_signed) return $signed(a) > $signed(b);
        return a > b;
    endfunction

    function automatic void swap_keys(int a, int b);
        logic [31:0] t;
        t = mdl_heap[a];
        mdl_heap[a] = mdl_heap[b];
        mdl_heap[b] = t;
    endfunction

    function automatic int climb(int ix);
        int p;
        while (ix > 0) begin
            p = (ix + 1) / 2 - 1;
            if (!key_gt(mdl_heap[ix], mdl_heap[p])) break;
            swap_keys(ix, p);
            ix = p;
        end
        return ix;
    endfunction

    function automatic void descend(int ix);
        int l, r, big;
        forever begin
            l = 2 * ix + 1;
            r = 2 * ix + 2;
            big = ix;
            if (l >= mdl_count) return;
            if (key_gt(mdl_heap[l], mdl_heap[big])) big = l;
            if (r < mdl_count && key_gt(mdl_heap[r], mdl_heap[big])) big = r;
            if (big == ix) return;
            swap_keys(ix, big);
            ix = big;
        end
    endfunction

    function automatic logic [31:0] take_slot(int ix);
        logic [31:0] k;
        k = mdl_heap[ix];
        mdl_count--;
        if (ix != mdl_count) begin
            mdl_heap[ix] = mdl_heap[mdl_count];
            if (climb(ix) == ix) descend(ix);
        end
        return k;
    endfunction

    function automatic t_heap_result predict_heap_op(logic [1:0] op, logic [31:0] key,
                                                     int pos);
        t_heap_result r;
        int cap, m;
        cap = (mdl_capacity > 64) ? 64 : mdl_capacity;
        r.key_out = '0;
        r.status  = ST_DONE;
        if (op == OP_INSERT) begin
            if (mdl_count >= cap) begin
                r.status = ST_FULL;
            end else begin
                mdl_heap[mdl_count] = key;
                mdl_count++;
                void'(climb(mdl_count - 1));
            end
        end else if (mdl_count == 0) begin
            r.status = ST_EMPTY;
        end else if (op == OP_EXT_MAX) begin
            r.key_out = mdl_heap[0];
            mdl_count--;
            mdl_heap[0] = mdl_heap[mdl_count];
            descend(0);
        end else if (op == OP_EXT_MIN) begin
            m = mdl_count / 2;
            for (int i = m + 1; i < mdl_count; i++)
                if (key_gt(mdl_heap[m], mdl_heap[i])) m = i;
            r.key_out = take_slot(m);
        end else begin
            if (pos >= mdl_count) r.status = ST_EMPTY;
            else r.key_out = take_slot(pos);
        end
        r.count_after = mdl_count[6:0];
        return r;
    endfunction

    // --- stimulus helpers ---
    // tvalid stays high between back-to-back requests
    task automatic send_request(logic [1:0] op, logic [31:0] key, logic [5:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, key, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_heap_op(op, key, int'(pos)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_CAPACITY) mdl_capacity = int'(val);
        else mdl_signed = val[0];
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // --- result checker ---
    always @(posedge i_clk) begin
        t_heap_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[40:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.key_out !== want.key_out) begin
                    $display("%0t: key_out exp %h got %h", $time, want.key_out, got.key_out);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (got.count_after !== want.count_after) begin
                    $display("%0t: count exp %0d got %0d", $time,
                             want.count_after, got.count_after);
                    error_count++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // --- tests ---
    task automatic test_directed();
        send_request(OP_EXT_MAX, 0, 0);            // empty heap
        send_request(OP_EXT_MIN, 0, 0);
        send_request(OP_EXT_IDX, 0, 0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 6'h3F);
        send_request(OP_INSERT, 32'h0, 0);
        send_request(OP_INSERT, 32'h8000_0000, 0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 0);
        send_request(OP_INSERT, 32'h5, 0);
        send_request(OP_INSERT, 32'h5, 0);         // equal keys
        send_request(OP_INSERT, 32'h5, 0);
        send_request(OP_EXT_IDX, 0, 6'h3F);        // out of range
        send_request(OP_EXT_IDX, 0, 2);
        send_request(OP_EXT_MIN, 0, 0);
        send_request(OP_EXT_MAX, 0, 0);
        send_request(OP_EXT_IDX, 0, 0);
        wait_drained();
        write_reg(REG_CAPACITY, 7'd2);             // below count: inserts refused
        send_request(OP_INSERT, 32'h9, 0);
        send_request(OP_EXT_MAX, 0, 0);
        wait_drained();
        write_reg(REG_CAPACITY, 7'd0);
        send_request(OP_INSERT, 32'h1, 0);
        wait_drained();
        write_reg(REG_CAPACITY, 7'd127);           // saturates at depth
    endtask

    task automatic test_random(int n, int fill_bias);
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < fill_bias) op = OP_INSERT;
            else op = 2'($urandom_range(3));
            send_request(op, rand_key(),
                         (mdl_count > 0 && $urandom_range(3) != 0) ?
                         6'($urandom_range(mdl_count - 1)) : 6'($urandom_range(63)));
        end
        wait_drained();
    endtask

    task automatic test_phase(int idle, int stall, logic [6:0] cap, bit sgn, int n);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_SIGNED, {6'd0, sgn});
        test_random(n / 2, 75);    // fill up
        test_random(n - n / 2, 25); // drain
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_wdata = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_count = 0;
        mdl_capacity = 64;
        mdl_signed = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phase(0, 0, 7'd64, 1'b0, 300);
        test_phase(63, 0, 7'd64, 1'b1, 300);
        test_phase(0, 63, 7'd1, 1'b0, 150);
        test_phase(10, 10, 7'd127, 1'b1, 300);
        test_phase(0, 0, 7'd5, 1'b1, 150);
        test_phase(10, 10, 7'd64, 1'b0, 150);
        if (error_count == 0)
            $display("[binary_max_heap_queue_core] OK");
        else
            $display("[binary_max_heap_queue_core] ERROR");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("[binary_max_heap_queue_core] ERROR");
        $finish;
    end
endmodule

/* sim.f */
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/binary_max_heap_queue_core.sv
bench/binary_max_heap_queue_core_tb.sv
